// ===== rtl/fan_curve_duty_controller_unit_macros.svh =====
// Assertion macros shared by the fan curve controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef FAN_CURVE_DUTY_CONTROLLER_UNIT_MACROS_SVH
`define FAN_CURVE_DUTY_CONTROLLER_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define FCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define FCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fcd_pkg.sv =====
// Shared widths, codes, default curve points and the controller/datapath
// command and status structs of the fan curve controller. No dependencies.
package fcd_pkg;

   // Field widths
   localparam int TEMP_W     = 8;
   localparam int DUTY_W     = 8;
   localparam int IDX_W      = 6;
   localparam int FAN_W      = 3;
   localparam int ACT_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_AUTO = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SET  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAN_SELECT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODIFY_ENABLE = 2'd1;

   // Fan number range and reset value
   localparam logic [FAN_W-1:0] FAN_RESET = 3'd1;
   localparam logic [FAN_W-1:0] FAN_LO    = 3'd1;
   localparam logic [FAN_W-1:0] FAN_HI    = 3'd4;

   // Default bracketing points
   localparam logic [TEMP_W-1:0] DEF_TMIN = 8'd0;
   localparam logic [TEMP_W-1:0] DEF_TMAX = 8'd120;
   localparam logic [DUTY_W-1:0] DEF_DMIN = 8'd40;
   localparam logic [DUTY_W-1:0] DEF_DMAX = 8'd100;

   // Special duty codes
   localparam logic [DUTY_W-1:0] DUTY_AUTO = 8'd0;
   localparam logic [DUTY_W-1:0] DUTY_KEEP = 8'd1;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

   // Arithmetic widths
   localparam int DIFF_W = TEMP_W + 1;        // signed differences
   localparam int PROD_W = 2 * DIFF_W;        // 9x9 signed product
   localparam int ACC_W  = PROD_W + 1;        // sum of two products
   localparam int NUM_W  = ACC_W + DUTY_W;    // times 255, signed
   localparam int NUMU_W = NUM_W - 1;         // magnitude of a non-negative numerator
   localparam int DEN_W  = 15;                // |span| * 100 <= 25500
   localparam int QUO_W  = DUTY_W;
   localparam int DSH_W  = DEN_W + QUO_W - 1; // divisor aligned to the top quotient bit
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load_write;   // store a curve point
      logic walk_start;   // capture an evaluate request
      logic walk_read;    // read the current curve entry
      logic walk_check;   // examine the entry read
      logic prod;         // first product and span
      logic sum;          // numerator before scaling
      logic scale;        // times 255, divisor, sign fold
      logic div_init;     // saturation check, divider load
      logic div_step;     // one quotient bit
      logic out_load;     // fill the response register
   } fcd_cmd_type;

   typedef struct packed {
      logic walk_stop;    // walk ends at this entry
      logic walk_below;   // temperature below the first point
   } fcd_status_type;

endpackage

// ===== rtl/fcd_req_if.sv =====
// Request channel of the fan curve controller: valid/ready plus the fields.
// Depends on fcd_pkg.
interface fcd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [fcd_pkg::IDX_W-1:0]   point_index;
   logic [fcd_pkg::TEMP_W-1:0]  point_temp;
   logic [fcd_pkg::DUTY_W-1:0]  point_duty;
   logic [fcd_pkg::TEMP_W-1:0]  temperature;
   logic [fcd_pkg::DUTY_W-1:0]  current_duty;

   modport source (output valid, op, point_index, point_temp, point_duty,
                   temperature, current_duty, input ready);
   modport sink   (input valid, op, point_index, point_temp, point_duty,
                   temperature, current_duty, output ready);
endinterface

// ===== rtl/fcd_rsp_if.sv =====
// Response channel of the fan curve controller: valid/ready plus the fields.
// Depends on fcd_pkg.
interface fcd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fcd_pkg::ACT_W-1:0]  action;
   logic [fcd_pkg::FAN_W-1:0]  fan_number;
   logic [fcd_pkg::DUTY_W-1:0] new_duty;

   modport source (output valid, action, fan_number, new_duty, input ready);
   modport sink   (input valid, action, fan_number, new_duty, output ready);
endinterface

// ===== rtl/fcd_csr_if.sv =====
// Register write channel of the fan curve controller: valid/ready, index, data.
// Depends on fcd_pkg.
interface fcd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fcd_pkg::CSR_IDX_W-1:0]  index;
   logic [fcd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fcd_datapath.sv =====
// Datapath of the fan curve controller: curve table, walk registers,
// interpolation arithmetic, serial divider, config and response registers.
// Depends on fcd_pkg and fcd_ram.
module fcd_datapath #(
   parameter int CURVE_POINTS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fcd_pkg::fcd_cmd_type           cmd,
   output fcd_pkg::fcd_status_type        status,
   input  logic [fcd_pkg::IDX_W-1:0]      point_index,
   input  logic [fcd_pkg::TEMP_W-1:0]     point_temp,
   input  logic [fcd_pkg::DUTY_W-1:0]     point_duty,
   input  logic [fcd_pkg::TEMP_W-1:0]     temperature,
   input  logic [fcd_pkg::DUTY_W-1:0]     current_duty,
   input  logic                           csr_write,
   input  logic [fcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fcd_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [fcd_pkg::ACT_W-1:0]      action,
   output logic [fcd_pkg::FAN_W-1:0]      fan_number,
   output logic [fcd_pkg::DUTY_W-1:0]     new_duty
);

   localparam int AW      = $clog2(CURVE_POINTS);
   localparam int WIDE_W  = 9;   // holds any point index and the table depth
   localparam int ENTRY_W = fcd_pkg::TEMP_W + fcd_pkg::DUTY_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(CURVE_POINTS - 1);

   // Configuration registers
   logic [fcd_pkg::FAN_W-1:0] fan_select_ff, fan_select_in;
   logic                      modify_ff, modify_in;

   // Curve table valid bits and write path
   logic [CURVE_POINTS-1:0] valid_ff, valid_in;
   logic [WIDE_W-1:0]       idx_wide;
   logic                    idx_in_range;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [ENTRY_W-1:0]      rd_data;

   // Walk registers
   logic [fcd_pkg::TEMP_W-1:0] t_ff, t_in;
   logic [fcd_pkg::DUTY_W-1:0] cur_ff, cur_in;
   logic [fcd_pkg::TEMP_W-1:0] tmin_ff, tmin_in, tmax_ff, tmax_in;
   logic [fcd_pkg::DUTY_W-1:0] dmin_ff, dmin_in, dmax_ff, dmax_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic                       entry_valid_ff, entry_valid_in;
   logic                       below_ff, below_in;
   logic [fcd_pkg::TEMP_W-1:0] e_temp;
   logic [fcd_pkg::DUTY_W-1:0] e_duty;
   logic                       end_mark, above, first, last;

   // Arithmetic registers
   logic [fcd_pkg::TEMP_W-1:0]        diff;
   logic signed [fcd_pkg::DIFF_W-1:0] dd_s;
   logic signed [fcd_pkg::DIFF_W-1:0] span_ff, span_in;
   logic signed [fcd_pkg::PROD_W-1:0] prod_a, prod_b;
   logic signed [fcd_pkg::PROD_W-1:0] p1_ff, p1_in;
   logic signed [fcd_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                              span_zero;
   logic signed [fcd_pkg::NUM_W-1:0]  acc_x, acc_sh, num_sel;
   logic [fcd_pkg::DIFF_W-1:0]        span_neg;
   logic [fcd_pkg::TEMP_W-1:0]        span_mag;
   logic [fcd_pkg::DEN_W-1:0]         den_calc;
   logic [fcd_pkg::NUMU_W-1:0]        numu_ff, numu_in;
   logic                              neg_ff, neg_in;
   logic [fcd_pkg::DEN_W-1:0]         den_ff, den_in;
   logic                              sat_ff, sat_in;
   logic [fcd_pkg::NUMU_W-1:0]        rem_ff, rem_in;
   logic [fcd_pkg::DSH_W-1:0]         dsh_ff, dsh_in;
   logic [fcd_pkg::QUO_W-1:0]         q_ff, q_in;
   logic                              fits;

   // Command decision and response registers
   logic [fcd_pkg::DUTY_W-1:0] duty;
   logic [fcd_pkg::DUTY_W-1:0] last_cmd_ff, last_cmd_in;
   logic                       fan_ok, issue;
   logic [fcd_pkg::ACT_W-1:0]  act;
   logic [fcd_pkg::ACT_W-1:0]  action_ff, action_in;
   logic [fcd_pkg::FAN_W-1:0]  fan_ff, fan_in;
   logic [fcd_pkg::DUTY_W-1:0] duty_ff, duty_in;

   // Decode register writes
   always_comb begin
      fan_select_in = fan_select_ff;
      modify_in     = modify_ff;
      if (csr_write) begin
         unique case (csr_index)
            fcd_pkg::CSR_FAN_SELECT:    fan_select_in = csr_data[fcd_pkg::FAN_W-1:0];
            fcd_pkg::CSR_MODIFY_ENABLE: modify_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fan_select_ff <= fcd_pkg::FAN_RESET;
         modify_ff     <= 1'b1;
      end else begin
         fan_select_ff <= fan_select_in;
         modify_ff     <= modify_in;
      end
   end

   // Store curve points; drop indexes beyond the table
   assign idx_wide     = WIDE_W'(point_index);
   assign idx_in_range = idx_wide < WIDE_W'(CURVE_POINTS);
   assign wr_en        = cmd.load_write && idx_in_range;
   assign wr_addr      = idx_wide[AW-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   fcd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CURVE_POINTS)
   ) u_curve_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({point_temp, point_duty}),
      .rd_en   (cmd.walk_read),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // An entry never written reads as zero
   assign e_temp = entry_valid_ff ? rd_data[ENTRY_W-1:fcd_pkg::DUTY_W] : '0;
   assign e_duty = entry_valid_ff ? rd_data[fcd_pkg::DUTY_W-1:0] : '0;

   assign end_mark = (e_temp == '0);
   assign above    = (t_ff < e_temp);
   assign first    = (addr_ff == '0);
   assign last     = (addr_ff == LAST_ADDR);

   assign status.walk_below = !end_mark && above && first;
   assign status.walk_stop  = end_mark || above || last;

   // Walk the curve: narrow the bracket one entry at a time
   always_comb begin
      t_in           = t_ff;
      cur_in         = cur_ff;
      tmin_in        = tmin_ff;
      tmax_in        = tmax_ff;
      dmin_in        = dmin_ff;
      dmax_in        = dmax_ff;
      addr_in        = addr_ff;
      entry_valid_in = entry_valid_ff;
      below_in       = below_ff;
      if (cmd.walk_start) begin
         t_in     = temperature;
         cur_in   = current_duty;
         tmin_in  = fcd_pkg::DEF_TMIN;
         tmax_in  = fcd_pkg::DEF_TMAX;
         dmin_in  = fcd_pkg::DEF_DMIN;
         dmax_in  = fcd_pkg::DEF_DMAX;
         addr_in  = '0;
         below_in = 1'b0;
      end
      if (cmd.walk_read) begin
         entry_valid_in = valid_ff[addr_ff];
      end
      if (cmd.walk_check) begin
         if (!end_mark) begin
            if (above) begin
               if (first) begin
                  below_in = 1'b1;
               end else begin
                  tmax_in = e_temp;
                  dmax_in = e_duty;
               end
            end else begin
               tmin_in = e_temp;
               dmin_in = e_duty;
            end
         end
         if (!status.walk_stop) begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff           <= t_in;
      cur_ff         <= cur_in;
      tmin_ff        <= tmin_in;
      tmax_ff        <= tmax_in;
      dmin_ff        <= dmin_in;
      dmax_ff        <= dmax_in;
      addr_ff        <= addr_in;
      entry_valid_ff <= entry_valid_in;
      below_ff       <= below_in;
   end

   // Interpolation terms; temperature never sits below the lower point
   assign diff   = t_ff - tmin_ff;
   assign dd_s   = $signed({1'b0, dmax_ff}) - $signed({1'b0, dmin_ff});
   assign prod_a = $signed({1'b0, diff}) * dd_s;
   assign prod_b = $signed({1'b0, dmin_ff}) * span_ff;

   assign span_zero = (span_ff == '0);

   // Times 255 as a shift and subtract; fold the divisor sign into it
   assign acc_x   = fcd_pkg::NUM_W'(acc_ff);
   assign acc_sh  = acc_x <<< fcd_pkg::DUTY_W;
   assign num_sel = span_ff[fcd_pkg::DIFF_W-1] ? (acc_x - acc_sh) : (acc_sh - acc_x);

   // Divisor |span| * 100 as 64 + 32 + 4; zero span divides dmin * 255 by 100
   assign span_neg = -span_ff;
   assign span_mag = span_zero ? fcd_pkg::TEMP_W'(1) :
                     (span_ff[fcd_pkg::DIFF_W-1] ? span_neg[fcd_pkg::TEMP_W-1:0]
                                                 : span_ff[fcd_pkg::TEMP_W-1:0]);
   assign den_calc = fcd_pkg::DEN_W'({span_mag, 6'b0}) + fcd_pkg::DEN_W'({span_mag, 5'b0})
                   + fcd_pkg::DEN_W'({span_mag, 2'b0});

   // One restoring step per cycle
   assign fits = (rem_ff >= fcd_pkg::NUMU_W'(dsh_ff));

   always_comb begin
      span_in = span_ff;
      p1_in   = p1_ff;
      acc_in  = acc_ff;
      numu_in = numu_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (cmd.prod) begin
         p1_in   = prod_a;
         span_in = $signed({1'b0, tmax_ff}) - $signed({1'b0, tmin_ff});
      end
      if (cmd.sum) begin
         acc_in = span_zero ? fcd_pkg::ACC_W'($signed({1'b0, dmin_ff}))
                            : fcd_pkg::ACC_W'(p1_ff) + fcd_pkg::ACC_W'(prod_b);
      end
      if (cmd.scale) begin
         neg_in  = num_sel[fcd_pkg::NUM_W-1];
         numu_in = num_sel[fcd_pkg::NUMU_W-1:0];
         den_in  = den_calc;
      end
      if (cmd.div_init) begin
         sat_in = numu_ff >= fcd_pkg::NUMU_W'({den_ff, {fcd_pkg::QUO_W{1'b0}}});
         rem_in = numu_ff;
         dsh_in = {den_ff, {(fcd_pkg::QUO_W-1){1'b0}}};
         q_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in = fits ? rem_ff - fcd_pkg::NUMU_W'(dsh_ff) : rem_ff;
         q_in   = {q_ff[fcd_pkg::QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      p1_ff   <= p1_in;
      acc_ff  <= acc_in;
      numu_ff <= numu_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      sat_ff  <= sat_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

   // Final duty: below the curve, negative, saturated or quotient
   always_comb begin
      if (below_ff) begin
         duty = (last_cmd_ff > fcd_pkg::DUTY_KEEP) ? fcd_pkg::DUTY_AUTO : fcd_pkg::DUTY_KEEP;
      end else if (neg_ff) begin
         duty = '0;
      end else if (sat_ff) begin
         duty = fcd_pkg::DUTY_FULL;
      end else begin
         duty = q_ff;
      end
   end

   // Decide the command and remember an issued duty
   assign fan_ok = (fan_select_ff >= fcd_pkg::FAN_LO) && (fan_select_ff <= fcd_pkg::FAN_HI);
   assign issue  = modify_ff && (duty != cur_ff);

   always_comb begin
      if (!issue || !fan_ok) begin
         act = fcd_pkg::ACT_NONE;
      end else if (duty == fcd_pkg::DUTY_AUTO) begin
         act = fcd_pkg::ACT_AUTO;
      end else if (duty == fcd_pkg::DUTY_KEEP) begin
         act = fcd_pkg::ACT_NONE;
      end else begin
         act = fcd_pkg::ACT_SET;
      end
   end

   always_comb begin
      last_cmd_in = last_cmd_ff;
      action_in   = action_ff;
      fan_in      = fan_ff;
      duty_in     = duty_ff;
      if (cmd.out_load) begin
         action_in = act;
         fan_in    = fan_select_ff;
         duty_in   = duty;
         if (issue) begin
            last_cmd_in = duty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cmd_ff <= '0;
      end else begin
         last_cmd_ff <= last_cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      fan_ff    <= fan_in;
      duty_ff   <= duty_in;
   end

   assign action     = action_ff;
   assign fan_number = fan_ff;
   assign new_duty   = duty_ff;

endmodule

// ===== rtl/fcd_controller.sv =====
// Sequencer of the fan curve controller: request handshake, curve walk,
// arithmetic steps, divider count and response valid. Depends on fcd_pkg.
`include "fan_curve_duty_controller_unit_macros.svh"

module fcd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fcd_pkg::fcd_cmd_type    cmd,
   input  fcd_pkg::fcd_status_type status
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_READ   = 9'b000000010,
      ST_CHECK  = 9'b000000100,
      ST_PROD   = 9'b000001000,
      ST_SUM    = 9'b000010000,
      ST_SCALE  = 9'b000100000,
      ST_DINIT  = 9'b001000000,
      ST_DIVIDE = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   localparam logic [fcd_pkg::CNT_W-1:0] CNT_LAST = fcd_pkg::CNT_W'(fcd_pkg::DIV_STEPS - 1);

   state_type                 state_ff, state_in;
   logic [fcd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accept;
   logic                      out_free;
   logic                      out_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == ST_FINISH) && out_free;

   // Next state and divider count
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.walk_below) begin
               state_in = ST_FINISH;
            end else if (status.walk_stop) begin
               state_in = ST_PROD;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_PROD:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DINIT;
         ST_DINIT: begin
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the response until the receiver takes it
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath commands
   assign cmd.load_write = accept && !req_op;
   assign cmd.walk_start = accept && req_op;
   assign cmd.walk_read  = (state_ff == ST_READ);
   assign cmd.walk_check = (state_ff == ST_CHECK);
   assign cmd.prod       = (state_ff == ST_PROD);
   assign cmd.sum        = (state_ff == ST_SUM);
   assign cmd.scale      = (state_ff == ST_SCALE);
   assign cmd.div_init   = (state_ff == ST_DINIT);
   assign cmd.div_step   = (state_ff == ST_DIVIDE);
   assign cmd.out_load   = out_load;

   assign rsp_valid = rsp_valid_ff;

   `FCD_ASSERT_NEXT(a_load_shows_response, clock, reset, out_load, rsp_valid_ff && state_ff == ST_IDLE, "response register load did not raise valid")
   `FCD_ASSERT_NEXT(a_stall_holds_finish, clock, reset, state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready, state_ff == ST_FINISH && rsp_valid_ff, "result overwrote a stalled response")
   `FCD_ASSERT_NEXT(a_divide_length, clock, reset, state_ff == ST_DIVIDE && cnt_ff == CNT_LAST, state_ff == ST_FINISH, "divider ran past its last quotient bit")

endmodule

// ===== rtl/fan_curve_duty_controller_unit.sv =====
// Top level of the piecewise-linear fan curve duty controller.
// Depends on fcd_pkg, the channel interfaces, fcd_controller and fcd_datapath.
//
// Usage:
//   req_bus carries load requests (op 0: store one curve point) and evaluate
//   requests (op 1: temperature and present duty). rsp_bus returns one
//   response per evaluate request: action, fan number and computed duty.
//   csr_bus writes fan_select (index 0) and modify_enable (index 1); it is
//   always ready and must only be used while the block is idle.
//   A load request is taken while the block is idle and leaves it idle. An
//   evaluate request walks the curve table, one read of the table RAM and one
//   compare per entry visited, then runs three arithmetic steps, a divider
//   load, a quotient loop of eight quotient bits and the response register
//   load. A temperature below the first point skips the arithmetic.
//   One evaluate request is handled at a time; the next request is taken
//   while the response still waits.
//   Reset clears the table (valid bits, immediately), the remembered command,
//   and sets fan_select to 1 and modify_enable to 1.
//   A stalled receiver holds the response; a finished evaluation then waits
//   and no further request is taken until the response register frees.
module fan_curve_duty_controller_unit #(
   parameter int CURVE_POINTS = 64
) (
   input  logic     clock,
   input  logic     reset,
   fcd_req_if.sink   req_bus,
   fcd_rsp_if.source rsp_bus,
   fcd_csr_if.sink   csr_bus
);

   fcd_pkg::fcd_cmd_type    cmd;
   fcd_pkg::fcd_status_type status;

   // Register writes are taken in any cycle
   assign csr_bus.ready = 1'b1;

   fcd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   fcd_datapath #(
      .CURVE_POINTS (CURVE_POINTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .point_index  (req_bus.point_index),
      .point_temp   (req_bus.point_temp),
      .point_duty   (req_bus.point_duty),
      .temperature  (req_bus.temperature),
      .current_duty (req_bus.current_duty),
      .csr_write    (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_data     (csr_bus.data),
      .action       (rsp_bus.action),
      .fan_number   (rsp_bus.fan_number),
      .new_duty     (rsp_bus.new_duty)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the fan curve duty controller: loads curves, evaluates
// temperatures and checks every response against a predictor kept in step with the block.
// Depends on fcd_pkg, the request/response/register channel interfaces and the top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fcd_pkg::*;

   localparam int CURVE_POINTS  = 64;
   localparam int STALL_LIMIT   = 3000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 2 * CURVE_POINTS + 20;
   localparam int SCALE_NUM     = 255;
   localparam int SCALE_DEN     = 100;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Unused register slots; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic              op;
      logic [IDX_W-1:0]  point_index;
      logic [TEMP_W-1:0] point_temp;
      logic [DUTY_W-1:0] point_duty;
      logic [TEMP_W-1:0] temperature;
      logic [DUTY_W-1:0] current_duty;
   } fan_request_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [FAN_W-1:0]  fan_number;
      logic [DUTY_W-1:0] new_duty;
   } fan_command_type;

   logic clock;
   logic reset;

   fcd_req_if req_bus ();
   fcd_rsp_if rsp_bus ();
   fcd_csr_if csr_bus ();

   fan_curve_duty_controller_unit #(.CURVE_POINTS(CURVE_POINTS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor state: curve table, remembered command and registers
   logic [TEMP_W-1:0] table_temp [CURVE_POINTS];
   logic [DUTY_W-1:0] table_duty [CURVE_POINTS];
   logic [DUTY_W-1:0] last_cmd_duty;
   logic [FAN_W-1:0]  cfg_fan;
   logic              cfg_modify;

   fan_command_type expected_fan_cmds [$];

   logic sender_idle_on;
   logic receiver_idle_on;
   logic hold_pending;

   int failures;
   int items_sent;
   int loads_seen;
   int evals_seen;
   int commands_seen;
   int settings_seen;

   logic [FAN_W-1:0] fan_plan    [0:7] = '{3'd1, 3'd4, 3'd4, 3'd0, 3'd2, 3'd5, 3'd7, 3'd3};
   logic             modify_plan [0:7] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Divide rounding toward minus infinity
   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic [DUTY_W-1:0] clamp_duty(input longint v);
      if (v < 0) return DUTY_AUTO;
      if (v > 255) return DUTY_FULL;
      return v[DUTY_W-1:0];
   endfunction

   // Walk the curve and interpolate the raw duty for one temperature
   function automatic logic [DUTY_W-1:0] interpolate_duty(input logic [TEMP_W-1:0] t);
      longint lo_t, hi_t, lo_d, hi_d, span, num;
      logic   walking;
      if (t < table_temp[0]) return (last_cmd_duty > DUTY_KEEP) ? DUTY_AUTO : DUTY_KEEP;
      lo_t = longint'(DEF_TMIN);
      hi_t = longint'(DEF_TMAX);
      lo_d = longint'(DEF_DMIN);
      hi_d = longint'(DEF_DMAX);
      walking = 1'b1;
      for (int i = 0; i < CURVE_POINTS && walking; i++) begin
         if (table_temp[i] == '0) begin
            walking = 1'b0;
         end else if (t < table_temp[i]) begin
            hi_t = longint'(table_temp[i]);
            hi_d = longint'(table_duty[i]);
            walking = 1'b0;
         end else begin
            lo_t = longint'(table_temp[i]);
            lo_d = longint'(table_duty[i]);
         end
      end
      span = hi_t - lo_t;
      if (span == 0) return clamp_duty(floor_quot(lo_d * SCALE_NUM, SCALE_DEN));
      num = ((longint'(t) - lo_t) * (hi_d - lo_d) + lo_d * span) * SCALE_NUM;
      return clamp_duty(floor_quot(num, SCALE_DEN * span));
   endfunction

   // Advance the predictor by one accepted request
   task automatic predict_fan_command(input fan_request_type item);
      fan_command_type cmd;
      if (item.op == OP_LOAD) begin
         table_temp[item.point_index] = item.point_temp;
         table_duty[item.point_index] = item.point_duty;
         loads_seen++;
      end else begin
         cmd.new_duty   = interpolate_duty(item.temperature);
         cmd.fan_number = cfg_fan;
         cmd.action     = ACT_NONE;
         if (cfg_modify && cmd.new_duty != item.current_duty) begin
            if (cfg_fan >= FAN_LO && cfg_fan <= FAN_HI) begin
               if (cmd.new_duty == DUTY_AUTO) cmd.action = ACT_AUTO;
               else if (cmd.new_duty != DUTY_KEEP) cmd.action = ACT_SET;
            end
            last_cmd_duty = cmd.new_duty;
         end
         expected_fan_cmds.push_back(cmd);
         evals_seen++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------------

   function automatic fan_request_type make_load(input int idx, input int temp, input int duty);
      fan_request_type item;
      item.op           = OP_LOAD;
      item.point_index  = IDX_W'(idx);
      item.point_temp   = TEMP_W'(temp);
      item.point_duty   = DUTY_W'(duty);
      item.temperature  = TEMP_W'($urandom);
      item.current_duty = DUTY_W'($urandom);
      return item;
   endfunction

   function automatic fan_request_type make_eval(input int temp, input int cur);
      fan_request_type item;
      item.op           = OP_EVAL;
      item.point_index  = IDX_W'($urandom);
      item.point_temp   = TEMP_W'($urandom);
      item.point_duty   = DUTY_W'($urandom);
      item.temperature  = TEMP_W'(temp);
      item.current_duty = DUTY_W'(cur);
      return item;
   endfunction

   // Offer one request, hold it until accepted, then advance the predictor
   task automatic send_request(input fan_request_type item);
      int gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.op           <= item.op;
      req_bus.point_index  <= item.point_index;
      req_bus.point_temp   <= item.point_temp;
      req_bus.point_duty   <= item.point_duty;
      req_bus.temperature  <= item.temperature;
      req_bus.current_duty <= item.current_duty;
      req_bus.valid        <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      predict_fan_command(item);
      items_sent++;
   endtask

   // Drop the request line and wait until every pending response has come back
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_fan_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      if (idx == CSR_FAN_SELECT) cfg_fan = value[FAN_W-1:0];
      else if (idx == CSR_MODIFY_ENABLE) cfg_modify = value[0];
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Write both registers once the block is idle; upper data bits carry noise
   task automatic configure(input logic [FAN_W-1:0] fan, input logic modify);
      logic [CSR_DATA_W-1:0] value;
      wait_idle();
      value = CSR_DATA_W'($urandom);
      value[FAN_W-1:0] = fan;
      write_register(CSR_FAN_SELECT, value);
      value = CSR_DATA_W'($urandom);
      value[0] = modify;
      write_register(CSR_MODIFY_ENABLE, value);
      settings_seen++;
   endtask

   // ---------------------------------------------------------------------
   // Random sequences
   // ---------------------------------------------------------------------

   // Load a rising curve, mostly short, sometimes filling the whole table
   task automatic program_curve();
      int n, t, duty;
      n = ($urandom_range(0, 9) == 0) ? CURVE_POINTS : $urandom_range(1, 8);
      t = (n == CURVE_POINTS) ? 0 : $urandom_range(0, 60);
      for (int k = 0; k < n; k++) begin
         t += (n == CURVE_POINTS) ? $urandom_range(1, 3) : $urandom_range(1, 40);
         if (t > 255) t = 255;
         duty = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 255) : $urandom_range(0, 100);
         send_request(make_load(k, t, duty));
      end
      // usually terminate; otherwise stale entries from older curves stay live
      if (n < CURVE_POINTS && $urandom_range(0, 7) != 0)
         send_request(make_load(n, 0, $urandom));
   endtask

   // Pick a temperature near a breakpoint, or anywhere
   function automatic logic [TEMP_W-1:0] pick_temperature();
      int k, t;
      if ($urandom_range(0, 2) == 0 || table_temp[0] == '0) return TEMP_W'($urandom_range(0, 255));
      k = $urandom_range(0, CURVE_POINTS - 1);
      if (table_temp[k] == '0) k = 0;
      t = int'(table_temp[k]) + int'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return TEMP_W'(t);
   endfunction

   task automatic send_evaluate();
      logic [TEMP_W-1:0] t;
      int cur;
      t = pick_temperature();
      case ($urandom_range(0, 5))
         0, 1: cur = int'(interpolate_duty(t));
         2:    cur = ($urandom_range(0, 1) == 0) ? int'(DUTY_AUTO) : int'(DUTY_KEEP);
         default: cur = $urandom_range(0, 255);
      endcase
      send_request(make_eval(int'(t), cur));
   endtask

   task automatic random_burst(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         case ($urandom_range(0, 11))
            0, 1: program_curve();
            2: send_request(make_load($urandom_range(0, CURVE_POINTS - 1),
                                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255),
                                      $urandom_range(0, 255)));
            default: send_evaluate();
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Evaluate against the built-in default points with an empty table
   task automatic test_default_curve();
      send_request(make_eval(0, 0));
      send_request(make_eval(255, 255));
   endtask

   // Interpolation, below-first-point, zero span, curve past 120, saturation
   task automatic test_curve_points();
      send_request(make_load(0, 30, 20));
      send_request(make_load(1, 60, 50));
      send_request(make_load(2, 120, 90));
      send_request(make_load(3, 0, 255));
      send_request(make_load(63, 255, 255));
      send_request(make_eval(10, 77));
      send_request(make_eval(10, 77));
      send_request(make_eval(45, $urandom));
      send_request(make_eval(60, 0));
      send_request(make_eval(120, 0));
      send_request(make_load(3, 200, 0));
      send_request(make_load(4, 0, 0));
      send_request(make_eval(250, 9));
      send_request(make_eval(150, 255));
      send_request(make_load(1, 60, 255));
      send_request(make_eval(59, 3));
   endtask

   // Report-only mode, fan number out of range, writes to unused slots
   task automatic test_registers();
      configure(3'd1, 1'b0);
      send_request(make_eval(45, 0));
      configure(3'd0, 1'b1);
      send_request(make_eval(45, 1));
      send_request(make_eval(10, 3));
      wait_idle();
      write_register(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_register(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      send_request(make_eval(100, 0));
      configure(3'd4, 1'b1);
      send_request(make_eval(100, 0));
   endtask

   // Phases of random traffic, each under its own register setting
   task automatic test_random_traffic();
      for (int p = 0; p < 8; p++) begin
         configure(fan_plan[p], modify_plan[p]);
         sender_idle_on   = (p == 0) || ($urandom_range(0, 3) != 0);
         receiver_idle_on = (p == 0) || ($urandom_range(0, 3) != 0);
         random_burst(90);
      end
   endtask

   // Stall the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      configure(3'd2, 1'b1);
      sender_idle_on = 1'b0;
      for (int k = 0; k < CURVE_POINTS; k++)
         send_request(make_load(k, 2 * k + 1, $urandom_range(0, 100)));
      hold_pending = 1'b1;
      for (int k = 0; k < 12; k++)
         send_request(make_eval($urandom_range(100, 255), $urandom));
      wait_idle();
   endtask

   // Closing stretch with no idling on either side
   task automatic test_steady_stream();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      random_burst(60);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_LOAD;
      req_bus.point_index  = '0;
      req_bus.point_temp   = '0;
      req_bus.point_duty   = '0;
      req_bus.temperature  = '0;
      req_bus.current_duty = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_FAN_SELECT;
      csr_bus.data         = '0;
      sender_idle_on       = 1'b1;
      receiver_idle_on     = 1'b1;
      hold_pending         = 1'b0;
      failures             = 0;
      items_sent           = 0;
      loads_seen           = 0;
      evals_seen           = 0;
      commands_seen        = 0;
      settings_seen        = 1;
      for (int i = 0; i < CURVE_POINTS; i++) begin
         table_temp[i] = '0;
         table_duty[i] = '0;
      end
      last_cmd_duty = '0;
      cfg_fan       = FAN_RESET;
      cfg_modify    = 1'b1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_curve();
      test_curve_points();
      test_registers();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();

      // drain, then allow one full walk for anything still in flight
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_fan_cmds.size() != 0) begin
         $display("%0t ns: %0d responses never arrived", $time, expected_fan_cmds.size());
         failures++;
      end

      $display("Ran %0d requests: %0d curve point loads and %0d evaluations, %0d commands issued,",
               items_sent, loads_seen, evals_seen, commands_seen);
      $display("under %0d register settings, with random stalls and one long response hold",
               settings_seen);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random stalls, plus the long hold when requested
   // ---------------------------------------------------------------------
   initial begin : response_sink
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_pending = 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : response_check
      fan_command_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_fan_cmds.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, %s %0d fan %0d duty %0d",
                     $time, "actual action", rsp_bus.action, rsp_bus.fan_number,
                     rsp_bus.new_duty);
            failures++;
         end else begin
            want = expected_fan_cmds.pop_front();
            if ($isunknown({rsp_bus.action, rsp_bus.fan_number, rsp_bus.new_duty})) begin
               $display("%0t ns: unknown bits in response, expected %h, actual %h", $time, want,
                        {rsp_bus.action, rsp_bus.fan_number, rsp_bus.new_duty});
               failures++;
            end else begin
               check_field("action", int'(want.action), int'(rsp_bus.action));
               check_field("fan_number", int'(want.fan_number), int'(rsp_bus.fan_number));
               check_field("new_duty", int'(want.new_duty), int'(rsp_bus.new_duty));
            end
            if (want.action != ACT_NONE) commands_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
